@@ sv/ray_frustum_intersect_assert.svh @@
// Assertion macros for the ray frustum intersect checker.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RAY_FRUSTUM_INTERSECT_ASSERT_SVH
`define RAY_FRUSTUM_INTERSECT_ASSERT_SVH

// same-cycle implication
`define AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/rfi_pkg.sv @@
// Shared types and constants for the ray frustum intersect block.
// No dependencies.
package rfi_pkg;

    localparam int REG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    localparam int PLANE_W   = 64;
    localparam int COORD_W   = 32;
    localparam int VEC_W     = 46;
    localparam int NUM_W     = 62;
    localparam int CNT_W     = 6;

    localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] T_MIN = 32'sh80000000;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_SUM  = 7'b0000100,
        ST_CHK  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

endpackage

@@ sv/ray_frustum_intersect.sv @@
// Top level: ray clipped against a ring of plane cells with one shared divider.
// Depends on rfi_pkg, rfi_cell, rfi_div.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | origin_x..z, dir_x..z
//  out     | output    | out_valid/out_stall | hit, entry_distance
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One ray at a time. Each plane goes through multiply, sum and check, then the
// serial divider and an update when a quotient is needed. The finished result
// sits in an output register; the next ray is taken while it waits. Reset
// clears all planes to zero.
module ray_frustum_intersect #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [31:0]                 origin_x,
    input  logic signed [31:0]                 origin_y,
    input  logic signed [31:0]                 origin_z,
    input  logic signed [31:0]                 dir_x,
    input  logic signed [31:0]                 dir_y,
    input  logic signed [31:0]                 dir_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic signed [31:0]                 entry_distance,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rfi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfi_pkg::PLANE_W-1:0]        cfg_data
);

    localparam int IW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int VW = rfi_pkg::VEC_W;

    rfi_pkg::state_t state_reg, state_next;

    logic [rfi_pkg::PLANE_W-1:0] plane_q [PLANE_COUNT];
    logic                        shift;
    logic [IW-1:0]               idx_reg, idx_next;

    logic signed [31:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic signed [43:0] pa_o_reg, pb_o_reg, pc_o_reg;
    logic signed [43:0] pa_d_reg, pb_d_reg, pc_d_reg;
    logic signed [41:0] pd_reg;
    logic signed [VW-1:0] vn_reg, vd_reg;
    logic signed [31:0] tnear_reg, tnear_next, tfar_reg, tfar_next;
    logic               hitacc_reg, hitacc_next;
    logic               out_valid_reg, out_valid_next;
    logic               hit_reg;
    logic signed [31:0] dist_reg;

    logic signed [11:0] pa, pb, pc;
    logic signed [27:0] pd;
    logic [VW-1:0]      vn_mag, vd_mag;
    logic               div_start, div_done;
    logic [rfi_pkg::NUM_W-1:0] quot;
    logic               t_neg, t_ovf;
    logic signed [31:0] t_val;
    logic               last;
    logic               load_out;

    genvar gi;
    generate
        for (gi = 0; gi < PLANE_COUNT; gi++)
        begin : g_cell
            rfi_pkg::cell_ctrl_t ctrl;
            assign ctrl.shift = shift;
            assign ctrl.wr    = (gi < rfi_pkg::REG_COUNT) && cfg_valid
                                && (cfg_index == rfi_pkg::CFG_IDX_W'(gi));
            rfi_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr_data   (cfg_data),
                .from_next (plane_q[(gi + 1) % PLANE_COUNT]),
                .plane     (plane_q[gi])
            );
        end
    endgenerate

    assign pa = plane_q[0][11:0];
    assign pb = plane_q[0][23:12];
    assign pc = plane_q[0][35:24];
    assign pd = plane_q[0][63:36];

    assign vn_mag = vn_reg[VW-1] ? VW'(-vn_reg) : VW'(vn_reg);
    assign vd_mag = vd_reg[VW-1] ? VW'(-vd_reg) : VW'(vd_reg);

    rfi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({vn_mag, 16'b0}),
        .den   (vd_mag),
        .quot  (quot),
        .done  (div_done)
    );

    // sign of -vn/vd; saturate to the Q16.16 range
    always_comb
    begin
        t_neg = (vn_reg > 0) ^ (vd_reg < 0);
        if (t_neg)
            t_ovf = (quot[61:32] != '0) || (quot[31] && (quot[30:0] != '0));
        else
            t_ovf = (quot[61:31] != '0);
        priority if (t_ovf)
            t_val = t_neg ? rfi_pkg::T_MIN : rfi_pkg::T_MAX;
        else if (t_neg)
            t_val = -$signed(quot[31:0]);
        else
            t_val = $signed(quot[31:0]);
    end

    assign last     = (idx_reg == IW'(PLANE_COUNT - 1));
    assign load_out = (state_reg == rfi_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tnear_next     = tnear_reg;
        tfar_next      = tfar_reg;
        hitacc_next    = hitacc_reg;
        shift          = 1'b0;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            rfi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next    = '0;
                    tnear_next  = rfi_pkg::T_MIN;
                    tfar_next   = rfi_pkg::T_MAX;
                    hitacc_next = 1'b1;
                    state_next  = rfi_pkg::ST_MUL;
                end
            end
            rfi_pkg::ST_MUL: state_next = rfi_pkg::ST_SUM;
            rfi_pkg::ST_SUM: state_next = rfi_pkg::ST_CHK;
            rfi_pkg::ST_CHK:
            begin
                if (hitacc_reg && (vd_reg != 0) && !((vd_reg > 0) && (vn_reg > 0)))
                begin
                    div_start  = 1'b1;
                    state_next = rfi_pkg::ST_DIV;
                end
                else
                begin
                    if (vn_reg > 0)
                        hitacc_next = 1'b0;
                    shift      = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = last ? rfi_pkg::ST_OUT : rfi_pkg::ST_MUL;
                end
            end
            rfi_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = rfi_pkg::ST_UPD;
            end
            rfi_pkg::ST_UPD:
            begin
                if (vd_reg > 0)
                begin
                    if (t_val < tfar_reg)
                    begin
                        tfar_next = t_val;
                        if (tnear_reg > t_val)
                            hitacc_next = 1'b0;
                    end
                end
                else if (t_val > tnear_reg)
                begin
                    tnear_next = t_val;
                    if (t_val > tfar_reg)
                        hitacc_next = 1'b0;
                end
                shift      = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = last ? rfi_pkg::ST_OUT : rfi_pkg::ST_MUL;
            end
            rfi_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = rfi_pkg::ST_IDLE;
                end
            end
            default: state_next = rfi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfi_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            hitacc_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            hitacc_reg    <= hitacc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tnear_reg <= tnear_next;
        tfar_reg  <= tfar_next;
        if ((state_reg == rfi_pkg::ST_IDLE) && in_valid)
        begin
            ox_reg <= origin_x;
            oy_reg <= origin_y;
            oz_reg <= origin_z;
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
        end
        if (state_reg == rfi_pkg::ST_MUL)
        begin
            pa_o_reg <= pa * ox_reg;
            pb_o_reg <= pb * oy_reg;
            pc_o_reg <= pc * oz_reg;
            pa_d_reg <= pa * dx_reg;
            pb_d_reg <= pb * dy_reg;
            pc_d_reg <= pc * dz_reg;
            pd_reg   <= {pd, 14'b0};
        end
        if (state_reg == rfi_pkg::ST_SUM)
        begin
            vn_reg <= VW'(pa_o_reg) + VW'(pb_o_reg) + VW'(pc_o_reg) + VW'(pd_reg);
            vd_reg <= VW'(pa_d_reg) + VW'(pb_d_reg) + VW'(pc_d_reg);
        end
        if (load_out)
        begin
            hit_reg  <= hitacc_reg;
            dist_reg <= hitacc_reg ? tnear_reg : 32'sd0;
        end
    end

    assign in_stall       = (state_reg != rfi_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign entry_distance = dist_reg;
    assign cfg_ready      = 1'b1;

endmodule

@@ sv/rfi_cell.sv @@
// One plane cell of the rotating plane ring.
// Depends on rfi_pkg.
module rfi_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rfi_pkg::cell_ctrl_t             ctrl,
    input  logic [rfi_pkg::PLANE_W-1:0]     wr_data,
    input  logic [rfi_pkg::PLANE_W-1:0]     from_next,
    output logic [rfi_pkg::PLANE_W-1:0]     plane
);

    logic [rfi_pkg::PLANE_W-1:0] plane_reg;
    logic [rfi_pkg::PLANE_W-1:0] plane_next;

    always_comb
    begin
        priority if (ctrl.wr)
            plane_next = wr_data;
        else if (ctrl.shift)
            plane_next = from_next;
        else
            plane_next = plane_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plane_reg <= '0;
        else
            plane_reg <= plane_next;
    end

    assign plane = plane_reg;

endmodule

@@ sv/rfi_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rfi_pkg.
module rfi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rfi_pkg::NUM_W-1:0]     num,
    input  logic [rfi_pkg::VEC_W-1:0]     den,
    output logic [rfi_pkg::NUM_W-1:0]     quot,
    output logic                          done
);

    localparam int NW = rfi_pkg::NUM_W;
    localparam int DW = rfi_pkg::VEC_W;

    logic [NW-1:0]             acc_reg, acc_next;
    logic [DW-1:0]             rem_reg, rem_next;
    logic [DW-1:0]             den_reg;
    logic [rfi_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DW:0]               rem_sh;
    logic [DW:0]               diff;
    logic                      ge;

    always_comb
    begin
        rem_sh    = {rem_reg, acc_reg[NW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        ge        = rem_sh >= {1'b0, den_reg};
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = num;
            rem_next  = '0;
            cnt_next  = rfi_pkg::CNT_W'(NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[NW-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign quot = acc_reg;
    assign done = done_reg;

endmodule

@@ sv/rfi_checker.sv @@
// Port-level checker for ray_frustum_intersect, bound to the top level.
// Depends on ray_frustum_intersect_assert.svh.
`include "ray_frustum_intersect_assert.svh"

module rfi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [31:0] entry_distance,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a miss never reports a distance
    `AST_IMPL(a_miss_zero, out_valid && !hit, entry_distance == 32'd0)
    // held result beat stays put
    `AST_NEXT(a_out_hold, out_valid && out_stall,
              out_valid && $stable(hit) && $stable(entry_distance))
    // an accepted ray occupies the block for the next cycle
    `AST_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // config is never back-pressured
    `AST_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind ray_frustum_intersect rfi_checker u_rfi_checker (.*);

@@ test/testbench.sv @@
// Testbench for ray_frustum_intersect: rays are clipped against configured plane sets
// and each result is checked against a local fixed-point model. Depends on rfi_pkg.
module testbench;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] entry;
    } clip_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic signed [31:0]              origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0]              dir_x = '0, dir_y = '0, dir_z = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            hit;
    logic signed [31:0]              entry_distance;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rfi_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [rfi_pkg::PLANE_W-1:0]     cfg_data = '0;

    logic [rfi_pkg::PLANE_W-1:0]     plane_regs [rfi_pkg::REG_COUNT];
    ray_t                            ray_queue [$];
    clip_t                           clip_queue [$];
    logic                            ray_taken = 1'b0;
    bit                              calm = 1'b0;
    int                              gap_left = 0;
    int                              stall_left = 0;
    int                              mismatches = 0;

    ray_frustum_intersect #(.PLANE_COUNT(6)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .origin_x       (origin_x),
        .origin_y       (origin_y),
        .origin_z       (origin_z),
        .dir_x          (dir_x),
        .dir_y          (dir_y),
        .dir_z          (dir_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .entry_distance (entry_distance),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] pack_plane(int a, int b, int c, int d);
        logic [11:0] fa, fb, fc;
        logic [27:0] fd;
        fa = a[11:0];
        fb = b[11:0];
        fc = c[11:0];
        fd = d[27:0];
        return {fd, fc, fb, fa};
    endfunction

    function automatic longint sat_q16(longint v);
        if (v > longint'(rfi_pkg::T_MAX))
            return longint'(rfi_pkg::T_MAX);
        if (v < longint'(rfi_pkg::T_MIN))
            return longint'(rfi_pkg::T_MIN);
        return v;
    endfunction

    function automatic clip_t clip_ray(ray_t r);
        longint ox, oy, oz, dx, dy, dz, a, b, c, d, vn, vd, t;
        longint t_near, t_far;
        logic   in_hull;
        clip_t  res;
        ox = r.ox; oy = r.oy; oz = r.oz;
        dx = r.dx; dy = r.dy; dz = r.dz;
        t_near = longint'(rfi_pkg::T_MIN);
        t_far = longint'(rfi_pkg::T_MAX);
        in_hull = 1'b1;
        for (int i = 0; i < rfi_pkg::REG_COUNT && in_hull; i++) begin
            a = longint'($signed(plane_regs[i][11:0]));
            b = longint'($signed(plane_regs[i][23:12]));
            c = longint'($signed(plane_regs[i][35:24]));
            d = longint'($signed(plane_regs[i][63:36]));
            vn = a * ox + b * oy + c * oz + d * 16384;
            vd = a * dx + b * dy + c * dz;
            if (vd == 0) begin
                // parallel plane: origin outside means miss
                if (vn > 0)
                    in_hull = 1'b0;
            end
            else begin
                t = sat_q16((-vn * 65536) / vd);
                if (vd > 0) begin
                    if (vn > 0)
                        in_hull = 1'b0;
                    else if (t < t_far) begin
                        t_far = t;
                        if (t_near > t_far)
                            in_hull = 1'b0;
                    end
                end
                else if (t > t_near) begin
                    t_near = t;
                    if (t_near > t_far)
                        in_hull = 1'b0;
                end
            end
        end
        res.hit = in_hull;
        res.entry = in_hull ? t_near[31:0] : 32'sd0;
        return res;
    endfunction

    // Ray driver: advance only after the current beat is taken
    always @(negedge clk) begin
        ray_t r;
        if (rst_n && (!in_valid || ray_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (ray_queue.size() > 0) begin
                r = ray_queue.pop_front();
                origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
                dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
                in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Predict on accepted rays, check accepted results
    always @(posedge clk) begin
        ray_t  r;
        clip_t want;
        ray_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            r.ox = origin_x; r.oy = origin_y; r.oz = origin_z;
            r.dx = dir_x; r.dy = dir_y; r.dz = dir_z;
            clip_queue.push_back(clip_ray(r));
        end
        if (rst_n && out_valid && !out_stall) begin
            if (clip_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0b entry=%0d", hit, entry_distance);
            end
            else begin
                want = clip_queue.pop_front();
                if (hit !== want.hit || entry_distance !== want.entry) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0b entry=%0d, got hit=%0b entry=%0d",
                                 want.hit, want.entry, hit, entry_distance);
                end
            end
        end
    end

    task automatic write_reg(int idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[rfi_pkg::CFG_IDX_W-1:0];
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < rfi_pkg::REG_COUNT)
            plane_regs[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every ray has come back, then let the block settle
    task automatic wait_idle();
        @(posedge clk);
        while (ray_queue.size() > 0 || in_valid || clip_queue.size() > 0)
            @(posedge clk);
        repeat (450) @(posedge clk);
    endtask

    task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        ray_queue.push_back(r);
    endtask

    function automatic int near_val(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_random_rays(int count);
        int span;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0)
                add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else begin
                span = 12 << 16;
                add_ray(near_val(span), near_val(span), near_val(span),
                        $urandom_range(0, 5) == 0 ? 0 : near_val(4 << 16),
                        $urandom_range(0, 5) == 0 ? 0 : near_val(4 << 16),
                        near_val(4 << 16));
            end
        end
    endtask

    // Axis-aligned box of half-size half_units, one plane per face
    task automatic load_box(int half_units);
        int dq;
        dq = -half_units * 4096;
        write_reg(0, pack_plane(0, 0, 1024, dq));
        write_reg(1, pack_plane(0, 0, -1024, dq));
        write_reg(2, pack_plane(-1024, 0, 0, dq));
        write_reg(3, pack_plane(1024, 0, 0, dq));
        write_reg(4, pack_plane(0, 1024, 0, dq));
        write_reg(5, pack_plane(0, -1024, 0, dq));
    endtask

    task automatic load_random_planes(bit wild);
        for (int i = 0; i < rfi_pkg::REG_COUNT; i++) begin
            if (wild)
                write_reg(i, {$urandom, $urandom});
            else
                write_reg(i, pack_plane(near_val(1024), near_val(1024), near_val(1024),
                                        -int'($urandom_range(0, 8 << 12))));
        end
    endtask

    initial begin
        #(12 * 6_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < rfi_pkg::REG_COUNT; i++)
            plane_regs[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all-zero planes: every ray hits at the lowest entry
        add_ray(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 0);
        add_ray(0, 0, 0, 0, 0, 0);
        wait_idle();

        load_box(4);
        add_ray(-10 << 16, 0, 0, 1 << 16, 0, 0);          // enters through the left face
        add_ray(10 << 16, 0, 0, 1 << 16, 0, 0);           // points away: negative t
        add_ray(0, 0, 0, 0, 0, 0);                        // zero direction, in the box
        add_ray(10 << 16, 0, 0, 0, 0, 0);                 // zero direction, outside
        add_ray(0, 0, 0, 1 << 16, 0, 0);                  // starts in the box
        add_ray(0, 10 << 16, 0, 1 << 16, 0, 0);           // parallel and outside
        add_ray(-10 << 16, 0, 0, 1, 0, 0);                // tiny step: quotient saturates
        add_ray(-10 << 16, 0, 0, 32'sh7fffffff, 0, 0);
        add_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_ray(-10 << 16, 6 << 16, 0, 1 << 16, 0, 0);    // misses past the top
        add_ray(-10 << 16, -10 << 16, -10 << 16, 1 << 16, 1 << 16, 1 << 16);
        add_ray(4 << 16, 0, 0, -1 << 16, 0, 0);           // origin on a face
        wait_idle();

        // extreme plane values, plus writes to indexes past the last plane
        write_reg(6, {64{1'b1}});
        write_reg(7, 64'h5555_aaaa_5555_aaaa);
        for (int i = 0; i < rfi_pkg::REG_COUNT; i++)
            write_reg(i, i[0] ? {64{1'b1}} : pack_plane(2047, -2048, 2047, 28'h7ffffff));
        add_random_rays(100);
        wait_idle();

        load_box(2 + $urandom_range(0, 6));
        add_random_rays(350);
        wait_idle();
        load_random_planes(1'b0);
        add_random_rays(350);
        wait_idle();
        load_random_planes(1'b1);
        add_random_rays(250);
        wait_idle();
        load_box(10);
        add_random_rays(350);
        wait_idle();

        calm = 1'b1;
        load_random_planes(1'b0);
        add_random_rays(300);
        wait_idle();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
